/* sv/sqbm_pkg.sv */
// Package for the store queue with byte merge: command and status codes,
// the input and result transaction structs, the entry struct and the cell control struct.
// No dependencies.
package sqbm_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_SHIFT  = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam int unsigned ROWS_W = 16;

  typedef struct packed {
    logic [1:0]         command;
    logic [31:0]        address;
    logic [31:0]        write_data;
    logic signed [31:0] time_tag;
    logic [3:0]         byte_enable;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               hit;
    logic [6:0]         entry_index;
    logic [31:0]        read_data;
    logic signed [31:0] read_time_tag;
    logic [6:0]         occupancy;
  } out_t;

  typedef struct packed {
    logic [31:0]        addr;
    logic [31:0]        data;
    logic signed [31:0] tag;
  } entry_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic               shift;
    logic               kill;
    logic               compact;
    logic               fresh;
    logic [31:0]        addr;
    logic [31:0]        wdata;
    logic [3:0]         be;
    logic signed [31:0] tag;
    logic [ROWS_W-1:0]  rows;
  } cell_ctrl_t;

endpackage

/* sv/sqbm_cell.sv */
// One queue cell: holds a valid bit and an entry, compares its address,
// merges writes and hands its entry down to the neighbour below during compaction.
// Depends on sqbm_pkg.
module sqbm_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sqbm_pkg::cell_ctrl_t ctrl_i,
  input  logic                wr_i,
  input  logic                lo_valid_i,
  input  logic                hi_valid_i,
  input  sqbm_pkg::entry_t    hi_entry_i,
  output logic                valid_o,
  output sqbm_pkg::entry_t    entry_o,
  output logic                match_o
);

  logic             valid_q, valid_d;
  sqbm_pkg::entry_t entry_q, entry_d;

  assign match_o = valid_q && (entry_q.addr == ctrl_i.addr);
  assign valid_o = valid_q;
  assign entry_o = entry_q;

  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    priority if (ctrl_i.shift) begin
      // Invalid cells are shifted as well; their tags are never read.
      entry_d.tag = entry_q.tag - $signed({16'd0, ctrl_i.rows});
    end else if (wr_i) begin
      valid_d      = 1'b1;
      entry_d.addr = ctrl_i.addr;
      entry_d.tag  = ctrl_i.tag;
      for (int k = 0; k < 4; k++) begin
        if (ctrl_i.be[k]) begin
          entry_d.data[8*k +: 8] = ctrl_i.wdata[8*k +: 8];
        end else if (ctrl_i.fresh) begin
          entry_d.data[8*k +: 8] = 8'h00;
        end
      end
    end else if (ctrl_i.kill) begin
      valid_d = valid_q && !match_o;
    end else if (ctrl_i.compact) begin
      // A hole takes the entry above it; the entry that moves leaves a hole.
      if (!valid_q && hi_valid_i) begin
        valid_d = 1'b1;
        entry_d = hi_entry_i;
      end else if (valid_q && !lo_valid_i) begin
        valid_d = 1'b0;
      end
    end else begin
      // Otherwise the cell keeps its contents.
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

/* sv/sqbm_enc.sv */
// One-hot to binary encoder over the cell chain.
// No dependencies.
module sqbm_enc #(
  parameter int unsigned N = 128
) (
  input  logic [N-1:0]         onehot_i,
  output logic [$clog2(N)-1:0] index_o
);

  localparam int unsigned W = $clog2(N);

  always_comb begin
    index_o = '0;
    for (int i = 0; i < N; i++) begin
      if (onehot_i[i]) begin
        index_o = index_o | W'(i);
      end
    end
  end

endmodule

/* sv/store_queue_byte_merge_cam_unit.sv */
// Store queue with byte merge: top level with the command sequencer and the cell chain.
// Depends on sqbm_pkg, sqbm_cell and sqbm_enc.
//
// Usage:
//   A transaction is accepted on a rising edge with start high and busy low;
//   cmd_i carries command, address, write data, time tag and byte enables.
//   Exactly one result per transaction appears on res_o for one cycle,
//   marked by result_valid_o. The receiver cannot stall; results are never held.
//   total_rows is written through cfg_we_i/cfg_wdata_i; the user must write it only
//   while the block is idle, which the block itself does not enforce.
// Sequence:
//   Insert, lookup, shift and a missed remove raise the result strobe after these
//   steps: address compare, first-match isolation, index and data selection, then
//   the update. busy falls with the strobe; a new transaction is accepted only once
//   busy is low. A remove that hits adds compaction: entries move down the cell chain
//   one cell per cycle into the holes until no hole is left; then the strobe rises.
// Reset:
//   Asynchronous, active low. All entries become invalid, the count and
//   total_rows clear. No clearing pass is needed; the block is ready at once.
module store_queue_byte_merge_cam_unit #(
  parameter int unsigned QUEUE_DEPTH = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  sqbm_pkg::in_t                 cmd_i,
  input  logic                          cfg_we_i,
  input  logic [sqbm_pkg::ROWS_W-1:0]   cfg_wdata_i,
  output logic                          result_valid_o,
  output sqbm_pkg::out_t                res_o
);

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned OW    = (IDX_W > 7) ? IDX_W : 7;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_CMP     = 3'd1;
  localparam logic [2:0] S_FIRST   = 3'd2;
  localparam logic [2:0] S_ENC     = 3'd3;
  localparam logic [2:0] S_APPLY   = 3'd4;
  localparam logic [2:0] S_COMPACT = 3'd5;

  logic [2:0]                     state_q, state_d;
  sqbm_pkg::in_t                  cmd_q;
  logic [sqbm_pkg::ROWS_W-1:0]    rows_q;
  logic [IDX_W-1:0]               count_q, count_d;
  logic [QUEUE_DEPTH-1:0]         match_q, oh_q;
  logic                           hit_q;
  logic [IDX_W-1:0]               idx_q;
  logic [31:0]                    rdata_q;
  logic signed [31:0]             rtag_q;
  sqbm_pkg::out_t                 res_q, res_d;
  logic                           res_valid_q, res_valid_d;

  sqbm_pkg::cell_ctrl_t           ctrl;
  logic [QUEUE_DEPTH-1:0]         wr, valid, match, boundary;
  sqbm_pkg::entry_t               ent [QUEUE_DEPTH];
  logic [IDX_W-1:0]               first_idx, bound_idx, new_count;
  logic [31:0]                    sel_data;
  logic signed [31:0]             sel_tag;
  logic                           hole;
  logic                           full;
  logic [OW-1:0]                  idx_wide, cnt_wide;

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign res_o          = res_q;

  // Cell chain.
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic             lo_v, hi_v;
    sqbm_pkg::entry_t hi_e;
    if (i == 0) begin : g_bot
      assign lo_v = 1'b1;
    end else begin : g_mid_lo
      assign lo_v = valid[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_top
      assign hi_v = 1'b0;
      assign hi_e = ent[i];
    end else begin : g_mid_hi
      assign hi_v = valid[i+1];
      assign hi_e = ent[i+1];
    end
    sqbm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .wr_i       (wr[i]),
      .lo_valid_i (lo_v),
      .hi_valid_i (hi_v),
      .hi_entry_i (hi_e),
      .valid_o    (valid[i]),
      .entry_o    (ent[i]),
      .match_o    (match[i])
    );
  end

  sqbm_enc #(.N(QUEUE_DEPTH)) u_first_enc (
    .onehot_i (oh_q),
    .index_o  (first_idx)
  );

  // After compaction the valid bits form a run from cell 0; the top of the run
  // gives the new count.
  assign boundary = valid & ~{1'b0, valid[QUEUE_DEPTH-1:1]};

  sqbm_enc #(.N(QUEUE_DEPTH)) u_count_enc (
    .onehot_i (boundary),
    .index_o  (bound_idx)
  );

  assign new_count = valid[0] ? (bound_idx + IDX_W'(1)) : '0;
  assign hole      = |(~valid[QUEUE_DEPTH-2:0] & valid[QUEUE_DEPTH-1:1]);
  assign full      = (count_q >= IDX_W'(QUEUE_DEPTH - 1));

  // Data of the first match, selected by the one-hot vector.
  always_comb begin
    sel_data = '0;
    sel_tag  = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (oh_q[i]) begin
        sel_data = sel_data | ent[i].data;
        sel_tag  = sel_tag | ent[i].tag;
      end
    end
  end

  always_comb begin
    ctrl.shift   = 1'b0;
    ctrl.kill    = 1'b0;
    ctrl.compact = 1'b0;
    ctrl.fresh   = !hit_q;
    ctrl.addr    = cmd_q.address;
    ctrl.wdata   = cmd_q.write_data;
    ctrl.be      = cmd_q.byte_enable;
    ctrl.tag     = cmd_q.time_tag;
    ctrl.rows    = rows_q;
    wr           = '0;
    state_d      = state_q;
    count_d      = count_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;
    idx_wide     = '0;
    cnt_wide     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        state_d = S_FIRST;
      end
      S_FIRST: begin
        state_d = S_ENC;
      end
      S_ENC: begin
        state_d = S_APPLY;
      end
      S_APPLY: begin
        res_valid_d         = 1'b1;
        res_d.status        = sqbm_pkg::ST_OK;
        res_d.hit           = 1'b0;
        res_d.entry_index   = '0;
        res_d.read_data     = '0;
        res_d.read_time_tag = '0;
        state_d             = S_IDLE;
        unique case (cmd_q.command)
          sqbm_pkg::CMD_INSERT: begin
            if (full) begin
              res_d.status = sqbm_pkg::ST_FULL;
            end else if (hit_q) begin
              wr                = oh_q;
              res_d.hit         = 1'b1;
              idx_wide          = OW'(idx_q);
              res_d.entry_index = idx_wide[6:0];
            end else begin
              for (int i = 0; i < QUEUE_DEPTH; i++) begin
                wr[i] = (count_q == IDX_W'(i));
              end
              idx_wide          = OW'(count_q);
              res_d.entry_index = idx_wide[6:0];
              count_d           = count_q + IDX_W'(1);
            end
          end
          sqbm_pkg::CMD_LOOKUP: begin
            if (hit_q) begin
              res_d.hit           = 1'b1;
              idx_wide            = OW'(idx_q);
              res_d.entry_index   = idx_wide[6:0];
              res_d.read_data     = rdata_q;
              res_d.read_time_tag = rtag_q;
            end else begin
              res_d.status = sqbm_pkg::ST_MISS;
            end
          end
          sqbm_pkg::CMD_REMOVE: begin
            if (hit_q) begin
              ctrl.kill   = 1'b1;
              res_valid_d = 1'b0;
              state_d     = S_COMPACT;
            end else begin
              res_d.status = sqbm_pkg::ST_MISS;
            end
          end
          sqbm_pkg::CMD_SHIFT: begin
            ctrl.shift = 1'b1;
          end
          default: begin
          end
        endcase
        cnt_wide        = OW'(count_d);
        res_d.occupancy = cnt_wide[6:0];
      end
      S_COMPACT: begin
        if (hole) begin
          ctrl.compact = 1'b1;
        end else begin
          count_d         = new_count;
          cnt_wide        = OW'(new_count);
          res_valid_d     = 1'b1;
          res_d.status    = sqbm_pkg::ST_OK;
          res_d.occupancy = cnt_wide[6:0];
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      rows_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        rows_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q <= cmd_i;
    end
    match_q <= match;
    // Isolate the lowest set bit: the first match in queue order.
    oh_q    <= match_q & (~match_q + QUEUE_DEPTH'(1));
    hit_q   <= |oh_q;
    idx_q   <= first_idx;
    rdata_q <= sel_data;
    rtag_q  <= sel_tag;
    res_q   <= res_d;
  end

endmodule
